/* hdl/turtle_grid_plotter_core_macros.svh */
// Assertion macros shared by the turtle grid plotter RTL.
`ifndef TURTLE_GRID_PLOTTER_CORE_MACROS_SVH
`define TURTLE_GRID_PLOTTER_CORE_MACROS_SVH
`ifndef SYNTH
`define TGP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("turtle grid plotter check failed");
`define TGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("turtle grid plotter check failed");
`else
`define TGP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TGP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/tgp_pkg.sv */
// Package with request and result types, command codes and control structs.
`timescale 1ns / 1ps
package tgp_pkg;

    localparam int CMD_W      = 3;
    localparam int STEP_W     = 8;
    localparam int ROW_BITS_W = 60;
    localparam int ROW_NUM_W  = 6;

    localparam logic [CMD_W-1:0] CMD_PEN_DOWN   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PEN_UP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TURN_RIGHT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TURN_LEFT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_OUT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MOVE       = 3'd5;

    localparam logic [1:0] HEAD_ROW_INC = 2'd0;
    localparam logic [1:0] HEAD_COL_INC = 2'd1;
    localparam logic [1:0] HEAD_ROW_DEC = 2'd2;
    localparam logic [1:0] HEAD_COL_DEC = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [STEP_W-1:0] step_count;
    } tgp_req_t;

    typedef struct packed {
        logic [ROW_BITS_W-1:0] row_bits;
        logic [ROW_NUM_W-1:0]  row_number;
        logic                  last;
    } tgp_result_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic mark;
        logic dump;
    } tgp_ctl_t;

    typedef struct packed {
        logic mark_go;
        logic dump_go;
        logic sweep_last;
    } tgp_sts_t;

endpackage

/* hdl/tgp_ram.sv */
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module tgp_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tgp_ctrl.sv */
// Controller state machine that sequences mark and read-out sweeps.
`timescale 1ns / 1ps
module tgp_ctrl import tgp_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  tgp_sts_t sts,
    output tgp_ctl_t ctl,
    output logic     busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MARK  = 4'b0010,
        S_DUMP  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    if (sts.mark_go)
                    begin
                        state_next = S_MARK;
                    end
                    else if (sts.dump_go)
                    begin
                        state_next = S_DUMP;
                    end
                end
            end
            S_MARK:
            begin
                ctl.rd   = 1'b1;
                ctl.mark = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_DUMP:
            begin
                ctl.rd   = 1'b1;
                ctl.dump = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* hdl/tgp_datapath.sv */
// Datapath with turtle state, canvas memory, row sweep counter and result register.
`timescale 1ns / 1ps
module tgp_datapath import tgp_pkg::*; #(
    parameter int ROWS = 40,
    parameter int COLS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  tgp_req_t    request,
    input  tgp_ctl_t    ctl,
    output tgp_sts_t    sts,
    output tgp_result_t result,
    output logic        result_valid
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int AW = (RW > CW) ? RW : CW;
    localparam int EW = ((AW > STEP_W) ? AW : STEP_W) + 1;
    localparam logic [EW-1:0] ROW_LIM  = EW'(ROWS - 1);
    localparam logic [EW-1:0] COL_LIM  = EW'(COLS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

    logic [RW-1:0]   pos_row_reg, pos_row_next;
    logic [CW-1:0]   pos_col_reg, pos_col_next;
    logic [1:0]      heading_reg, heading_next;
    logic            pen_reg, pen_next;
    logic [RW-1:0]   cur_reg, cur_next;
    logic [RW-1:0]   stop_reg, stop_next;
    logic            down_reg, down_next;
    logic [COLS-1:0] mask_reg, mask_next;
    logic            wr_pend_reg, out_pend_reg;
    logic [RW-1:0]   rd_row_reg;
    logic            hit_reg;
    logic [ROWS-1:0] valid_reg, valid_next;

    logic [EW-1:0]   n_e, pr_e, pc_e;
    logic [EW-1:0]   r_sum, r_sum1, c_sum, c_sum1;
    logic [EW-1:0]   r_fwd_pos, r_fwd_end, r_bwd_pos, r_bwd_end;
    logic [EW-1:0]   c_fwd_pos, c_fwd_end, c_bwd_pos, c_bwd_end;
    logic [CW-1:0]   lo_c, hi_c;
    logic [COLS-1:0] mask_h, mask_v;
    logic [COLS-1:0] ram_q, row_data;
    logic [ROW_BITS_W+COLS-1:0] row_wide;
    logic [ROW_NUM_W+RW-1:0]    num_wide;

    assign n_e  = EW'(request.step_count);
    assign pr_e = EW'(pos_row_reg);
    assign pc_e = EW'(pos_col_reg);

    assign r_sum     = pr_e + n_e;
    assign r_sum1    = r_sum - EW'(1);
    assign r_fwd_pos = (r_sum > ROW_LIM) ? ROW_LIM : r_sum;
    assign r_fwd_end = (r_sum1 > ROW_LIM) ? ROW_LIM : r_sum1;
    assign r_bwd_pos = (n_e > pr_e) ? '0 : pr_e - n_e;
    assign r_bwd_end = (n_e > pr_e) ? '0 : pr_e - n_e + EW'(1);

    assign c_sum     = pc_e + n_e;
    assign c_sum1    = c_sum - EW'(1);
    assign c_fwd_pos = (c_sum > COL_LIM) ? COL_LIM : c_sum;
    assign c_fwd_end = (c_sum1 > COL_LIM) ? COL_LIM : c_sum1;
    assign c_bwd_pos = (n_e > pc_e) ? '0 : pc_e - n_e;
    assign c_bwd_end = (n_e > pc_e) ? '0 : pc_e - n_e + EW'(1);

    assign lo_c   = heading_reg[1] ? c_bwd_end[CW-1:0] : pos_col_reg;
    assign hi_c   = heading_reg[1] ? pos_col_reg : c_fwd_end[CW-1:0];
    assign mask_h = ({COLS{1'b1}} << lo_c) & ({COLS{1'b1}} >> (COL_LAST - hi_c));
    assign mask_v = COLS'(1) << pos_col_reg;

    always_comb
    begin
        pos_row_next = pos_row_reg;
        pos_col_next = pos_col_reg;
        heading_next = heading_reg;
        pen_next     = pen_reg;
        cur_next     = cur_reg;
        stop_next    = stop_reg;
        down_next    = down_reg;
        mask_next    = mask_reg;
        if (ctl.load)
        begin
            unique case (request.cmd)
                CMD_PEN_DOWN:   pen_next = 1'b1;
                CMD_PEN_UP:     pen_next = 1'b0;
                CMD_TURN_RIGHT: heading_next = heading_reg + 2'd1;
                CMD_TURN_LEFT:  heading_next = heading_reg + 2'd3;
                CMD_READ_OUT:
                begin
                    cur_next  = '0;
                    stop_next = ROW_LAST;
                    down_next = 1'b0;
                end
                CMD_MOVE:
                begin
                    case (heading_reg)
                        HEAD_ROW_INC:
                        begin
                            pos_row_next = r_fwd_pos[RW-1:0];
                            cur_next     = pos_row_reg;
                            stop_next    = r_fwd_end[RW-1:0];
                            down_next    = 1'b0;
                            mask_next    = mask_v;
                        end
                        HEAD_ROW_DEC:
                        begin
                            pos_row_next = r_bwd_pos[RW-1:0];
                            cur_next     = pos_row_reg;
                            stop_next    = r_bwd_end[RW-1:0];
                            down_next    = 1'b1;
                            mask_next    = mask_v;
                        end
                        HEAD_COL_INC:
                        begin
                            pos_col_next = c_fwd_pos[CW-1:0];
                            cur_next     = pos_row_reg;
                            stop_next    = pos_row_reg;
                            down_next    = 1'b0;
                            mask_next    = mask_h;
                        end
                        default:
                        begin
                            pos_col_next = c_bwd_pos[CW-1:0];
                            cur_next     = pos_row_reg;
                            stop_next    = pos_row_reg;
                            down_next    = 1'b0;
                            mask_next    = mask_h;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        else if (ctl.rd && !sts.sweep_last)
        begin
            cur_next = down_reg ? cur_reg - RW'(1) : cur_reg + RW'(1);
        end
    end

    assign valid_next = wr_pend_reg ? (valid_reg | (ROWS'(1) << rd_row_reg)) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_row_reg  <= '0;
            pos_col_reg  <= '0;
            heading_reg  <= HEAD_ROW_INC;
            pen_reg      <= 1'b1;
            wr_pend_reg  <= 1'b0;
            out_pend_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            pos_row_reg  <= pos_row_next;
            pos_col_reg  <= pos_col_next;
            heading_reg  <= heading_next;
            pen_reg      <= pen_next;
            wr_pend_reg  <= ctl.rd & ctl.mark;
            out_pend_reg <= ctl.rd & ctl.dump;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        stop_reg   <= stop_next;
        down_reg   <= down_next;
        mask_reg   <= mask_next;
        rd_row_reg <= cur_reg;
        hit_reg    <= valid_reg[cur_reg];
    end

    // A row that was never written since reset reads as blank.
    assign row_data = hit_reg ? ram_q : '0;

    tgp_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_canvas (
        .clk   (clk),
        .we    (wr_pend_reg),
        .waddr (rd_row_reg),
        .wdata (row_data | mask_reg),
        .re    (ctl.rd),
        .raddr (cur_reg),
        .rdata (ram_q)
    );

    assign sts.mark_go    = (request.cmd == CMD_MOVE) && pen_reg && (request.step_count != '0);
    assign sts.dump_go    = (request.cmd == CMD_READ_OUT);
    assign sts.sweep_last = (cur_reg == stop_reg);

    assign row_wide          = {{ROW_BITS_W{1'b0}}, row_data};
    assign num_wide          = {{ROW_NUM_W{1'b0}}, rd_row_reg};
    assign result.row_bits   = row_wide[ROW_BITS_W-1:0];
    assign result.row_number = num_wide[ROW_NUM_W-1:0];
    assign result.last       = (rd_row_reg == ROW_LAST);
    assign result_valid      = out_pend_reg;

endmodule

/* hdl/turtle_grid_plotter_core.sv */
// Pen, turn and unused commands finish in the accept cycle; busy stays low.
// A move with the pen down and a nonzero step keeps busy high while it marks
// each row it touches, one canvas row per cycle through the read-modify-write
// path, then flushes. Read out: each row appears once its canvas read is
// registered; all ROWS rows come on consecutive cycles, then a flush.
// Reset clears the canvas at once through per-row valid flags; no clearing pass.
`timescale 1ns / 1ps
`include "turtle_grid_plotter_core_macros.svh"
module turtle_grid_plotter_core import tgp_pkg::*; #(
    parameter int ROWS = 40,
    parameter int COLS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tgp_req_t    request,
    output tgp_result_t result,
    output logic        result_valid
);

    tgp_ctl_t ctl;
    tgp_sts_t sts;

    tgp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    tgp_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .ctl          (ctl),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

    `TGP_ASSERT_SAME(a_result_while_busy, clk, rst_n, result_valid, busy)
    `TGP_ASSERT_NEXT(a_no_result_after_accept, clk, rst_n, start && !busy, !result_valid)
    `TGP_ASSERT_NEXT(a_rows_back_to_back, clk, rst_n, result_valid && !result.last, result_valid)
    `TGP_ASSERT_NEXT(a_idle_after_last, clk, rst_n, result_valid && result.last, !busy)

endmodule
